// File: rtl/core/scfl_pkg.sv
// Package with the types, constants and helper functions of the size-class allocator.
package scfl_pkg;

    // Geometry of the size classes and the handle space.
    localparam int TINY_CLASSES      = 64;
    localparam int MEDIUM_CLASSES    = 64;
    localparam int TOTAL_CLASSES     = TINY_CLASSES + MEDIUM_CLASSES;
    localparam int TINY_STEP_BYTES   = 8;
    localparam int MEDIUM_STEP_BYTES = 1024;
    localparam int ALIGN_BYTES       = 8;
    localparam int HANDLES           = 8192;
    localparam int HANDLE_W          = 13;
    localparam int CLASS_W           = 8;
    localparam int CLASS_AW          = 7;
    localparam int BYTES_W           = 25;
    localparam int TINY_PRELOAD      = TINY_CLASSES * TINY_CLASSES;
    localparam int PRELOAD           = TINY_PRELOAD + MEDIUM_CLASSES;
    localparam int TINY_MAX_BYTES    = TINY_CLASSES * TINY_STEP_BYTES;
    localparam int MEDIUM_MAX_BYTES  = MEDIUM_CLASSES * MEDIUM_STEP_BYTES;
    localparam logic [CLASS_W-1:0] NO_CLASS = CLASS_W'(TOTAL_CLASSES);

    // Result codes.
    typedef enum logic [2:0] {
        STAT_POPPED   = 3'd0,
        STAT_FRESH    = 3'd1,
        STAT_OVER     = 3'd2,
        STAT_NO_HANDLE = 3'd3,
        STAT_RETURNED = 3'd4,
        STAT_RETIRED  = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_CHK,
        S_ALLOC_POP,
        S_ALLOC_SPARE,
        S_FREE_CHK,
        S_FREE_PUSH,
        S_DONE
    } t_state;

    // One chunk record and one class list record.
    typedef struct packed {
        logic               in_use;
        logic [CLASS_W-1:0] cls;
        logic [BYTES_W-1:0] bytes;
    } t_chunk;

    typedef struct packed {
        logic [HANDLE_W-1:0] head;
        logic [HANDLE_W-1:0] tail;
        logic [HANDLE_W:0]   count;
    } t_row;

    // Byte size of a class.
    function automatic logic [BYTES_W-1:0] class_size(input logic [CLASS_W-1:0] c);
        logic [BYTES_W-1:0] cw;
        cw = BYTES_W'(c);
        if (int'(c) < TINY_CLASSES) begin
            return (cw + BYTES_W'(1)) * BYTES_W'(TINY_STEP_BYTES);
        end
        return (cw - BYTES_W'(TINY_CLASSES) + BYTES_W'(1)) * BYTES_W'(MEDIUM_STEP_BYTES);
    endfunction

    // Class of an aligned size; sizes above every class map to the no-class code.
    function automatic logic [CLASS_W-1:0] size_to_class(input logic [BYTES_W-1:0] a);
        logic [BYTES_W-1:0] am1;
        am1 = a - BYTES_W'(1);
        if (a > BYTES_W'(MEDIUM_MAX_BYTES)) begin
            return NO_CLASS;
        end
        if (a <= BYTES_W'(TINY_MAX_BYTES)) begin
            return (a == '0) ? '0 : CLASS_W'(am1 / TINY_STEP_BYTES);
        end
        return CLASS_W'(TINY_CLASSES) + CLASS_W'(am1 / MEDIUM_STEP_BYTES);
    endfunction

    // Chunk record of a handle right after reset.
    function automatic t_chunk preload_chunk(input logic [HANDLE_W-1:0] h);
        t_chunk r;
        r.in_use = 1'b0;
        if (int'(h) < TINY_PRELOAD) begin
            r.cls = CLASS_W'(h / TINY_CLASSES);
        end else if (int'(h) < PRELOAD) begin
            r.cls = CLASS_W'(h - HANDLE_W'(TINY_PRELOAD)) + CLASS_W'(TINY_CLASSES);
        end else begin
            r.cls = NO_CLASS;
        end
        r.bytes = (r.cls == NO_CLASS) ? '0 : class_size(r.cls);
        return r;
    endfunction

    // Link of a handle right after reset: tiny chunks chain to the next handle within their class.
    function automatic logic [HANDLE_W:0] preload_link(input logic [HANDLE_W-1:0] h);
        if (int'(h) < TINY_PRELOAD && int'(h % TINY_CLASSES) != TINY_CLASSES - 1) begin
            return (HANDLE_W+1)'(h) + (HANDLE_W+1)'(1);
        end
        return '0;
    endfunction

    // Class list record right after reset.
    function automatic t_row preload_row(input logic [CLASS_AW-1:0] c);
        t_row r;
        if (int'(c) < TINY_CLASSES) begin
            r.head  = HANDLE_W'(c) * HANDLE_W'(TINY_CLASSES);
            r.tail  = r.head + HANDLE_W'(TINY_CLASSES - 1);
            r.count = (HANDLE_W+1)'(TINY_CLASSES);
        end else begin
            r.head  = HANDLE_W'(c) - HANDLE_W'(TINY_CLASSES) + HANDLE_W'(TINY_PRELOAD);
            r.tail  = r.head;
            r.count = (HANDLE_W+1)'(1);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/scfl_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module scfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: rtl/core/size_class_free_list_allocator.sv
// Size-class allocator: after reset a clearing pass loads the chunk, link and class-list
// memories, during which no item is accepted (configuration writes are). Each item then
// runs from acceptance to its registered result, one at a time. The short case is an
// allocate decided by the limit check, a never-used handle or handle exhaustion, and a free
// that is ignored or retires an oversized chunk. The long case is a pop, which reads the
// class list record, then the head's link, then writes the class list record and the chunk
// record; a spare handle, which reads its stack link; and a push, which reads the chunk
// record, then the class list record, then writes the tail link and record. The next item
// is accepted in the cycle after the result is registered. A finished result waits in the
// output register while the next item is accepted; a result that cannot enter the stalled
// output register holds the block in its last step.
module size_class_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [23:0] i_req_size,
    input  logic [12:0] i_chunk_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [12:0] o_granted_handle,
    output logic [23:0] o_granted_size,
    output logic [7:0]  o_size_class,
    output logic [31:0] o_used_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    localparam int HW = scfl_pkg::HANDLE_W;
    localparam int CW = scfl_pkg::CLASS_W;
    localparam int AW = scfl_pkg::CLASS_AW;
    localparam int BW = scfl_pkg::BYTES_W;

    scfl_pkg::t_state r_state, n_state;

    logic [HW-1:0] r_handle, n_handle;
    logic [BW-1:0] r_aligned, n_aligned;
    logic [BW-1:0] r_size, n_size;
    logic [CW-1:0] r_class, n_class;
    logic [HW-1:0] r_g, n_g;
    logic [31:0]   r_used, n_used;
    logic [HW:0]   r_fresh, n_fresh;
    logic [HW:0]   r_spare, n_spare;
    logic [11:0]   r_limit;
    logic [HW:0]   r_init, n_init;

    scfl_pkg::t_status r_res_status, n_res_status;
    logic [HW-1:0] r_res_handle, n_res_handle;
    logic [BW-1:0] r_res_size, n_res_size;
    logic [CW-1:0] r_res_class, n_res_class;
    logic [31:0]   r_res_used, n_res_used;
    logic          r_out_valid;
    logic [23:0]   r_out_size;

    // Memory ports.
    logic                 chunk_we, chunk_re;
    logic [HW-1:0]        chunk_waddr, chunk_raddr;
    scfl_pkg::t_chunk     chunk_wdata, chunk_rdata;
    logic                 link_we, link_re;
    logic [HW-1:0]        link_waddr, link_raddr;
    logic [HW:0]          link_wdata, link_rdata;
    logic                 row_we, row_re;
    logic [AW-1:0]        row_waddr, row_raddr;
    scfl_pkg::t_row       row_wdata, row_rdata;

    logic          accept, out_free, over_limit;
    logic [BW-1:0] in_aligned;
    logic [CW-1:0] in_class;
    logic [32:0]   need;

    assign o_stall     = (r_state != scfl_pkg::S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    assign in_aligned = (BW'(i_req_size) + BW'(scfl_pkg::ALIGN_BYTES - 1))
                      & ~BW'(scfl_pkg::ALIGN_BYTES - 1);
    assign in_class   = scfl_pkg::size_to_class(in_aligned);
    assign need       = {1'b0, r_used} + 33'(r_aligned);
    assign over_limit = need > {1'b0, r_limit, 20'd0};

    scfl_ram #(.WIDTH($bits(scfl_pkg::t_chunk)), .DEPTH(scfl_pkg::HANDLES)) u_chunk_ram (
        .i_clk(i_clk), .i_we(chunk_we), .i_waddr(chunk_waddr), .i_wdata(chunk_wdata),
        .i_re(chunk_re), .i_raddr(chunk_raddr), .o_rdata(chunk_rdata)
    );

    scfl_ram #(.WIDTH(HW + 1), .DEPTH(scfl_pkg::HANDLES)) u_link_ram (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_re(link_re), .i_raddr(link_raddr), .o_rdata(link_rdata)
    );

    scfl_ram #(.WIDTH($bits(scfl_pkg::t_row)), .DEPTH(scfl_pkg::TOTAL_CLASSES)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_re(row_re), .i_raddr(row_raddr), .o_rdata(row_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scfl_pkg::S_INIT: begin
                if (r_init == (HW+1)'(scfl_pkg::HANDLES - 1)) begin
                    n_state = scfl_pkg::S_IDLE;
                end
            end
            scfl_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_cmd ? scfl_pkg::S_FREE_CHK : scfl_pkg::S_ALLOC_CHK;
                end
            end
            scfl_pkg::S_ALLOC_CHK: begin
                if (over_limit) begin
                    n_state = scfl_pkg::S_DONE;
                end else if (r_class != scfl_pkg::NO_CLASS && row_rdata.count != '0) begin
                    n_state = scfl_pkg::S_ALLOC_POP;
                end else if (!r_spare[HW]) begin
                    n_state = scfl_pkg::S_ALLOC_SPARE;
                end else begin
                    n_state = scfl_pkg::S_DONE;
                end
            end
            scfl_pkg::S_FREE_CHK: begin
                if (chunk_rdata.in_use && chunk_rdata.cls != scfl_pkg::NO_CLASS) begin
                    n_state = scfl_pkg::S_FREE_PUSH;
                end else begin
                    n_state = scfl_pkg::S_DONE;
                end
            end
            scfl_pkg::S_ALLOC_POP,
            scfl_pkg::S_ALLOC_SPARE,
            scfl_pkg::S_FREE_PUSH: begin
                n_state = scfl_pkg::S_DONE;
            end
            scfl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = scfl_pkg::S_IDLE;
                end
            end
            default: n_state = scfl_pkg::S_INIT;
        endcase
    end

    // Memory control and datapath.
    always_comb begin
        n_handle     = r_handle;
        n_aligned    = r_aligned;
        n_size       = r_size;
        n_class      = r_class;
        n_g          = r_g;
        n_used       = r_used;
        n_fresh      = r_fresh;
        n_spare      = r_spare;
        n_init       = r_init;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_size   = r_res_size;
        n_res_class  = r_res_class;
        n_res_used   = r_res_used;
        chunk_we     = 1'b0;
        chunk_waddr  = r_g;
        chunk_wdata  = '{in_use: 1'b1, cls: r_class, bytes: r_size};
        chunk_re     = 1'b0;
        chunk_raddr  = i_chunk_handle;
        link_we      = 1'b0;
        link_waddr   = r_handle;
        link_wdata   = r_spare;
        link_re      = 1'b0;
        link_raddr   = row_rdata.head;
        row_we       = 1'b0;
        row_waddr    = r_class[AW-1:0];
        row_wdata    = row_rdata;
        row_re       = 1'b0;
        row_raddr    = in_class[AW-1:0];

        unique case (r_state)
            // Clearing pass: load every memory with its reset contents.
            scfl_pkg::S_INIT: begin
                n_init      = r_init + (HW+1)'(1);
                chunk_we    = 1'b1;
                chunk_waddr = r_init[HW-1:0];
                chunk_wdata = scfl_pkg::preload_chunk(r_init[HW-1:0]);
                link_we     = 1'b1;
                link_waddr  = r_init[HW-1:0];
                link_wdata  = scfl_pkg::preload_link(r_init[HW-1:0]);
                row_we      = (int'(r_init) < scfl_pkg::TOTAL_CLASSES);
                row_waddr   = r_init[AW-1:0];
                row_wdata   = scfl_pkg::preload_row(r_init[AW-1:0]);
            end
            // Take the item and start reading its class record or chunk record.
            scfl_pkg::S_IDLE: begin
                if (accept) begin
                    n_handle  = i_chunk_handle;
                    n_aligned = in_aligned;
                    n_class   = in_class;
                    n_size    = (in_class == scfl_pkg::NO_CLASS) ? in_aligned
                              : scfl_pkg::class_size(in_class);
                    row_re    = !i_cmd;
                    chunk_re  = i_cmd;
                end
            end
            // Limit check, then pop, take a spare handle or a never-used one.
            scfl_pkg::S_ALLOC_CHK: begin
                n_res_handle = '0;
                n_res_class  = r_class;
                n_res_used   = r_used;
                if (over_limit) begin
                    n_res_status = scfl_pkg::STAT_OVER;
                    n_res_size   = '0;
                end else if (r_class != scfl_pkg::NO_CLASS && row_rdata.count != '0) begin
                    n_g        = row_rdata.head;
                    link_re    = 1'b1;
                    link_raddr = row_rdata.head;
                end else if (!r_spare[HW]) begin
                    n_g        = r_spare[HW-1:0];
                    link_re    = 1'b1;
                    link_raddr = r_spare[HW-1:0];
                end else if (!r_fresh[HW]) begin
                    n_fresh      = r_fresh + (HW+1)'(1);
                    chunk_we     = 1'b1;
                    chunk_waddr  = r_fresh[HW-1:0];
                    n_used       = r_used + 32'(r_size);
                    n_res_used   = n_used;
                    n_res_status = scfl_pkg::STAT_FRESH;
                    n_res_handle = r_fresh[HW-1:0];
                    n_res_size   = r_size;
                end else begin
                    n_res_status = scfl_pkg::STAT_NO_HANDLE;
                    n_res_size   = '0;
                end
            end
            // Unlink the head of the class list.
            scfl_pkg::S_ALLOC_POP: begin
                row_we          = 1'b1;
                row_wdata.head  = link_rdata[HW-1:0];
                row_wdata.count = row_rdata.count - (HW+1)'(1);
                chunk_we        = 1'b1;
                n_used          = r_used + 32'(r_size);
                n_res_used      = n_used;
                n_res_status    = scfl_pkg::STAT_POPPED;
                n_res_handle    = r_g;
                n_res_size      = r_size;
            end
            // Pop the spare stack.
            scfl_pkg::S_ALLOC_SPARE: begin
                n_spare      = link_rdata;
                chunk_we     = 1'b1;
                n_used       = r_used + 32'(r_size);
                n_res_used   = n_used;
                n_res_status = scfl_pkg::STAT_FRESH;
                n_res_handle = r_g;
                n_res_size   = r_size;
            end
            // Check the freed handle; retire oversized ones at once.
            scfl_pkg::S_FREE_CHK: begin
                n_class      = chunk_rdata.cls;
                n_size       = chunk_rdata.bytes;
                n_res_handle = '0;
                n_res_used   = r_used;
                n_res_status = scfl_pkg::STAT_RETIRED;
                n_res_class  = scfl_pkg::NO_CLASS;
                n_res_size   = '0;
                row_raddr    = chunk_rdata.cls[AW-1:0];
                chunk_waddr  = r_handle;
                chunk_wdata  = chunk_rdata;
                chunk_wdata.in_use = 1'b0;
                if (chunk_rdata.in_use) begin
                    n_used     = r_used - 32'(chunk_rdata.bytes);
                    n_res_used = n_used;
                    n_res_size = chunk_rdata.bytes;
                    chunk_we   = 1'b1;
                    if (chunk_rdata.cls == scfl_pkg::NO_CLASS) begin
                        link_we    = 1'b1;
                        link_waddr = r_handle;
                        link_wdata = r_spare;
                        n_spare    = (HW+1)'(r_handle);
                    end else begin
                        row_re = 1'b1;
                    end
                end
            end
            // Append the handle at the tail of its class list.
            scfl_pkg::S_FREE_PUSH: begin
                row_we          = 1'b1;
                row_wdata.tail  = r_handle;
                row_wdata.count = row_rdata.count + (HW+1)'(1);
                if (row_rdata.count == '0) begin
                    row_wdata.head = r_handle;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = row_rdata.tail;
                    link_wdata = (HW+1)'(r_handle);
                end
                n_res_status = scfl_pkg::STAT_RETURNED;
                n_res_class  = r_class;
            end
            scfl_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scfl_pkg::S_INIT;
            r_init      <= '0;
            r_used      <= '0;
            r_fresh     <= (HW+1)'(scfl_pkg::PRELOAD);
            r_spare     <= (HW+1)'(scfl_pkg::HANDLES);
            r_limit     <= 12'd64;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_used  <= n_used;
            r_fresh <= n_fresh;
            r_spare <= n_spare;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == scfl_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_handle     <= n_handle;
        r_aligned    <= n_aligned;
        r_size       <= n_size;
        r_class      <= n_class;
        r_g          <= n_g;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_size   <= n_res_size;
        r_res_class  <= n_res_class;
        r_res_used   <= n_res_used;
        if (r_state == scfl_pkg::S_DONE && out_free) begin
            o_status         <= r_res_status;
            o_granted_handle <= r_res_handle;
            o_size_class     <= r_res_class;
            o_used_total     <= r_res_used;
            r_out_size       <= r_res_size[BW-1] ? 24'hFFFFFF : r_res_size[23:0];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_granted_size = r_out_size;

endmodule

// File: rtl/core/scfl_checker.sv
// Port-level checker for the size-class allocator and its bind.
module scfl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [12:0] o_granted_handle,
    input logic [23:0] o_granted_size,
    input logic [7:0]  o_size_class
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Failed allocations grant nothing.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == scfl_pkg::STAT_OVER || o_status == scfl_pkg::STAT_NO_HANDLE)
        |-> o_granted_handle == 13'd0 && o_granted_size == 24'd0)
        else $error("failed allocate carries a grant");

    // A handle returned to a list names a real class.
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == scfl_pkg::STAT_RETURNED
        |-> o_size_class < scfl_pkg::NO_CLASS && o_granted_handle == 13'd0)
        else $error("returned item has bad class");

    // Retired or ignored frees report no class.
    a_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == scfl_pkg::STAT_RETIRED
        |-> o_size_class == scfl_pkg::NO_CLASS && o_granted_handle == 13'd0)
        else $error("retired item has a class");

endmodule

bind size_class_free_list_allocator scfl_checker u_scfl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_status(o_status), .o_granted_handle(o_granted_handle),
    .o_granted_size(o_granted_size), .o_size_class(o_size_class)
);
